>>> rtl/core/cr55_pkg.sv
// ============================================================================
// cr55_pkg
// Shared types, register codes and helpers of the circulant Ramsey(5,5)
// witness checker: command and status bundles between controller and datapath.
// ============================================================================
package cr55_pkg;

    localparam int DEG_W = 6;
    localparam int VC_W  = 7;
    localparam int CFG_W = 7;
    localparam int IDX_W = 2;

    typedef logic [IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_VERTEX_COUNT = 2'd0;
    localparam cfg_idx_t CFG_MIN_DEGREE   = 2'd1;
    localparam cfg_idx_t CFG_MAX_DEGREE   = 2'd2;

    // Search depth of the shared pick unit.
    typedef logic [1:0] lvl_t;

    localparam lvl_t LVL_A = 2'd0;
    localparam lvl_t LVL_B = 2'd1;
    localparam lvl_t LVL_C = 2'd2;

    typedef struct packed {
        logic load;
        logic start;
        logic init_far;
        logic step;
        lvl_t level;
        logic publish;
        logic hit;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic a_empty;
        logic b_empty;
        logic c_empty;
        logic found;
    } status_t;

    // Population count of a 32-bit word as a five-level adder tree.
    function automatic logic [DEG_W-1:0] pop32(input logic [31:0] v);
        logic [31:0] x;
        x = v - ((v >> 1) & 32'h5555_5555);
        x = (x & 32'h3333_3333) + ((x >> 2) & 32'h3333_3333);
        x = (x + (x >> 4)) & 32'h0F0F_0F0F;
        x = x + (x >> 8);
        x = x + (x >> 16);
        return x[DEG_W-1:0];
    endfunction

endpackage

>>> rtl/core/cr55_datapath.sv
// ============================================================================
// cr55_datapath
// Edge vector, degree, candidate sets of the three search depths and the
// shared pick-and-rotate unit, plus the result register.
// ============================================================================
module cr55_datapath
    import cr55_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic                                 clk,
    input  cmd_t                                 cmd,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]    n_eff,
    input  logic [DEG_W-1:0]                     min_degree,
    input  logic [DEG_W-1:0]                     max_degree,
    input  logic [31:0]                          distance_set,
    output status_t                              status,
    output logic                                 hit,
    output logic [DEG_W-1:0]                     degree,
    output logic                                 degree_in_range
);

    localparam int V    = MAX_VERTICES;
    localparam int VW   = $clog2(V);
    localparam int NW   = $clog2(V + 1);
    localparam int HALF = V / 2;

    logic [V-1:0]     e_reg, e_next;
    logic [V-1:0]     adj_reg, adj_next;
    logic [V-1:0]     pa_reg, pa_next;
    logic [V-1:0]     pb_reg, pb_next;
    logic [V-1:0]     pc_reg, pc_next;
    logic [DEG_W-1:0] deg_reg, deg_next;
    logic             hit_reg;
    logic [DEG_W-1:0] degree_reg;
    logic             in_range_reg;

    logic [NW-1:0]    half;
    logic [V-1:0]     low_vec;
    logic [V-1:0]     rev_vec;
    logic [V-1:0]     mirror;
    logic [V-1:0]     nmask;
    logic [V-1:0]     nonedge;
    logic             mid;
    logic [DEG_W:0]   deg_wide;
    logic             in_range;

    logic [V-1:0]     sel;
    logic [V-1:0]     rest;
    logic [V-1:0]     row;
    logic [V-1:0]     nbr;
    logic [VW-1:0]    pick;

    // Edge vector: distance d lands at bit d, its mirror at bit n-d.
    always_comb
    begin
        half    = n_eff >> 1;
        low_vec = '0;
        for (int i = 0; i < HALF; i++)
        begin
            low_vec[i] = (NW'(i) < half) & distance_set[i];
        end
        for (int i = 0; i < V; i++)
        begin
            rev_vec[i] = low_vec[V-1-i];
            nmask[i]   = NW'(i) < n_eff;
        end
        mirror   = rev_vec >> (NW'(V) - n_eff);
        e_next   = (low_vec << 1) | mirror;
        // The middle distance of an even graph is its own mirror.
        mid      = !n_eff[0] && low_vec[VW'(half - NW'(1))];
        deg_wide = {pop32(32'(low_vec[HALF-1:0])), 1'b0} - (DEG_W+1)'(mid);
        deg_next = deg_wide[DEG_W-1:0];
        nonedge  = ~e_reg & nmask & ~V'(1);
        in_range = (deg_reg >= min_degree) && (deg_reg <= max_degree);
    end

    // Shared unit: take the lowest candidate, drop it, and keep the rest
    // that is adjacent to it. Row v of a circulant graph is row 0 rotated by v.
    always_comb
    begin
        case (cmd.level)
            LVL_A:   sel = pa_reg;
            LVL_B:   sel = pb_reg;
            default: sel = pc_reg;
        endcase
        pick = '0;
        for (int i = V - 1; i >= 0; i--)
        begin
            if (sel[i])
            begin
                pick = VW'(i);
            end
        end
        rest = sel & (sel - V'(1));
        row  = ((adj_reg << pick) | (adj_reg >> (n_eff - NW'(pick)))) & nmask;
        nbr  = rest & row;
    end

    always_comb
    begin
        adj_next = adj_reg;
        pa_next  = pa_reg;
        pb_next  = pb_reg;
        pc_next  = pc_reg;
        if (cmd.start)
        begin
            adj_next = e_reg;
            pa_next  = e_reg;
        end
        else if (cmd.init_far)
        begin
            adj_next = nonedge;
            pa_next  = nonedge;
        end
        else if (cmd.step)
        begin
            case (cmd.level)
                LVL_A:
                begin
                    pa_next = rest;
                    pb_next = nbr;
                end
                LVL_B:
                begin
                    pb_next = rest;
                    pc_next = nbr;
                end
                default:
                begin
                    pc_next = rest;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e_reg   <= e_next;
            deg_reg <= deg_next;
        end
        adj_reg <= adj_next;
        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
        pc_reg  <= pc_next;
        if (cmd.publish)
        begin
            hit_reg      <= cmd.hit;
            degree_reg   <= deg_reg;
            in_range_reg <= in_range;
        end
    end

    assign status.in_range = in_range;
    assign status.a_empty  = (pa_reg == '0);
    assign status.b_empty  = (pb_reg == '0);
    assign status.c_empty  = (pc_reg == '0);
    assign status.found    = (nbr != '0);

    assign hit             = hit_reg;
    assign degree          = degree_reg;
    assign degree_in_range = in_range_reg;

endmodule

>>> rtl/core/cr55_ctrl.sv
// ============================================================================
// cr55_ctrl
// Controller of the checker: takes an item, walks the depth-first clique
// search over neighbors and then non-neighbors, and hands the result over.
// ============================================================================
module cr55_ctrl
    import cr55_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DEG      = 3'd1;
    localparam logic [2:0] S_LA       = 3'd2;
    localparam logic [2:0] S_LB       = 3'd3;
    localparam logic [2:0] S_LC       = 3'd4;
    localparam logic [2:0] S_FIN_MISS = 3'd5;
    localparam logic [2:0] S_FIN_HIT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       far_reg, far_next;
    logic       out_valid_reg, out_valid_next;
    logic       can_publish;

    assign can_publish = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd        = '0;
        cmd.level  = LVL_A;
        state_next = state_reg;
        far_next   = far_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEG;
                end
            end
            S_DEG:
            begin
                if (status.in_range)
                begin
                    cmd.start  = 1'b1;
                    far_next   = 1'b0;
                    state_next = S_LA;
                end
                else
                begin
                    state_next = S_FIN_MISS;
                end
            end
            S_LA:
            begin
                cmd.level = LVL_A;
                if (!status.a_empty)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_LB;
                end
                else if (!far_reg)
                begin
                    // Neighbors hold no 4-clique; search the complement next.
                    cmd.init_far = 1'b1;
                    far_next     = 1'b1;
                end
                else
                begin
                    state_next = S_FIN_HIT;
                end
            end
            S_LB:
            begin
                cmd.level = LVL_B;
                if (!status.b_empty)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_LC;
                end
                else
                begin
                    state_next = S_LA;
                end
            end
            S_LC:
            begin
                cmd.level = LVL_C;
                if (status.c_empty)
                begin
                    state_next = S_LB;
                end
                else if (status.found)
                begin
                    state_next = S_FIN_MISS;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_FIN_MISS:
            begin
                if (can_publish)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_FIN_HIT:
            begin
                if (can_publish)
                begin
                    cmd.publish = 1'b1;
                    cmd.hit     = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = cmd.publish | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            far_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            far_reg       <= far_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/circulant_ramsey55_checker.sv
// ============================================================================
// circulant_ramsey55_checker
// Decides whether one distance set of a circulant graph is a Ramsey(5,5)
// witness: degree in range and no 4-clique among the neighbors or the
// non-neighbors of vertex 0.
// ============================================================================
// One item first builds the edge vector and checks the degree, then runs
// the steps of a depth-first clique search, then hands the result to the
// output register. A step visits one candidate vertex at one of three depths
// through a single shared pick-and-rotate unit, so the search time grows with
// the number of vertex pairs and triples explored, and the search is skipped
// when the degree is out of range. The next item is taken once the result is
// in the output register, even if that result is still waiting to be
// transferred.
module circulant_ramsey55_checker
    import cr55_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [31:0]       distance_set,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    output logic [DEG_W-1:0]  degree,
    output logic              degree_in_range
);

    localparam int NW = $clog2(MAX_VERTICES + 1);

    logic [VC_W-1:0]  vertex_count_reg, vertex_count_next;
    logic [DEG_W-1:0] min_degree_reg, min_degree_next;
    logic [DEG_W-1:0] max_degree_reg, max_degree_next;
    logic [NW-1:0]    n_eff;
    cmd_t             cmd;
    status_t          status;

    always_comb
    begin
        vertex_count_next = vertex_count_reg;
        min_degree_next   = min_degree_reg;
        max_degree_next   = max_degree_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_VERTEX_COUNT: vertex_count_next = cfg_data;
                CFG_MIN_DEGREE:   min_degree_next   = cfg_data[DEG_W-1:0];
                CFG_MAX_DEGREE:   max_degree_next   = cfg_data[DEG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VC_W'(43);
            min_degree_reg   <= DEG_W'(18);
            max_degree_reg   <= DEG_W'(24);
        end
        else
        begin
            vertex_count_reg <= vertex_count_next;
            min_degree_reg   <= min_degree_next;
            max_degree_reg   <= max_degree_next;
        end
    end

    // The vertex count saturates to the supported range.
    always_comb
    begin
        if (vertex_count_reg < VC_W'(2))
        begin
            n_eff = NW'(2);
        end
        else if (vertex_count_reg > VC_W'(MAX_VERTICES))
        begin
            n_eff = NW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = NW'(vertex_count_reg);
        end
    end

    cr55_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    cr55_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath
    (
        .clk             (clk),
        .cmd             (cmd),
        .n_eff           (n_eff),
        .min_degree      (min_degree_reg),
        .max_degree      (max_degree_reg),
        .distance_set    (distance_set),
        .status          (status),
        .hit             (hit),
        .degree          (degree),
        .degree_in_range (degree_in_range)
    );

endmodule

>>> verif/cr55_witness_monitor.sv
`timescale 1ns / 1ps
// ============================================================================
// cr55_witness_monitor
// Follows the register writes and both transfer channels of the circulant
// Ramsey(5,5) witness checker. For every distance set taken in, it works out
// the degree and the clique verdict, then matches each result transfer,
// field by field, against the oldest verdict still owed.
// ============================================================================
module cr55_witness_monitor
    import cr55_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [31:0]      distance_set,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic             hit,
    input  logic [DEG_W-1:0] degree,
    input  logic             degree_in_range,
    output int               fail_count,
    output int               outstanding
);

    typedef struct packed {
        logic             hit;
        logic [DEG_W-1:0] degree;
        logic             degree_in_range;
    } verdict_t;

    localparam logic [VC_W-1:0]  VERTICES_RESET = 7'd43;
    localparam logic [DEG_W-1:0] DEG_LO_RESET   = 6'd18;
    localparam logic [DEG_W-1:0] DEG_HI_RESET   = 6'd24;

    logic [VC_W-1:0]  vertices;
    logic [DEG_W-1:0] degree_lo;
    logic [DEG_W-1:0] degree_hi;
    verdict_t         verdict_q[$];

    function automatic int unsigned ring_dist(input int unsigned b, input int unsigned a,
                                              input int unsigned n);
        return (b >= a) ? b - a : b + n - a;
    endfunction

    // True when four members of the list are pairwise joined under adj.
    function automatic bit has_k4(input logic [63:0] adj, input int unsigned members[64],
                                  input int unsigned cnt, input int unsigned n);
        for (int unsigned a = 0; a < cnt; a++)
        begin
            for (int unsigned b = a + 1; b < cnt; b++)
            begin
                if (!adj[ring_dist(members[b], members[a], n)])
                    continue;
                for (int unsigned c = b + 1; c < cnt; c++)
                begin
                    if (!adj[ring_dist(members[c], members[a], n)] ||
                        !adj[ring_dist(members[c], members[b], n)])
                        continue;
                    for (int unsigned e = c + 1; e < cnt; e++)
                    begin
                        if (adj[ring_dist(members[e], members[a], n)] &&
                            adj[ring_dist(members[e], members[b], n)] &&
                            adj[ring_dist(members[e], members[c], n)])
                            return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic verdict_t predict_witness(input logic [31:0] dset,
                                                 input logic [VC_W-1:0] vc,
                                                 input logic [DEG_W-1:0] lo,
                                                 input logic [DEG_W-1:0] hi);
        logic [63:0] joined;
        logic [63:0] apart;
        int unsigned near_v[64];
        int unsigned far_v[64];
        int unsigned near_n;
        int unsigned far_n;
        int unsigned n;
        int unsigned deg;
        verdict_t    v;

        // The vertex count saturates at both ends of its range.
        n = (vc < 2) ? 2 : ((vc > MAX_VERTICES) ? MAX_VERTICES : vc);
        joined = '0;
        apart  = '0;
        near_n = 0;
        far_n  = 0;
        deg    = 0;
        for (int unsigned d = 1; d <= n / 2; d++)
        begin
            if (dset[d - 1])
            begin
                joined[d]     = 1'b1;
                joined[n - d] = 1'b1;
                // The middle distance is its own mirror and counts once.
                deg += (d == n - d) ? 1 : 2;
            end
        end
        v.degree          = deg[DEG_W-1:0];
        v.degree_in_range = (deg >= lo) && (deg <= hi);
        v.hit             = 1'b0;
        if (v.degree_in_range)
        begin
            for (int unsigned i = 1; i < n; i++)
            begin
                if (joined[i])
                begin
                    near_v[near_n] = i;
                    near_n++;
                end
                else
                begin
                    far_v[far_n] = i;
                    far_n++;
                    apart[i] = 1'b1;
                end
            end
            v.hit = !has_k4(joined, near_v, near_n, n) && !has_k4(apart, far_v, far_n, n);
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        int       errs;
        int       delta;

        if (!rst_n)
        begin
            vertices    <= VERTICES_RESET;
            degree_lo   <= DEG_LO_RESET;
            degree_hi   <= DEG_HI_RESET;
            fail_count  <= 0;
            outstanding <= 0;
            verdict_q.delete();
        end
        else
        begin
            errs  = 0;
            delta = 0;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_VERTEX_COUNT: vertices  <= cfg_data[VC_W-1:0];
                    CFG_MIN_DEGREE:   degree_lo <= cfg_data[DEG_W-1:0];
                    CFG_MAX_DEGREE:   degree_hi <= cfg_data[DEG_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result transfer with no verdict pending");
                    errs++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    delta--;
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        errs++;
                    end
                    if (degree !== want.degree)
                    begin
                        $error("degree: expected %0d, got %0d", want.degree, degree);
                        errs++;
                    end
                    if (degree_in_range !== want.degree_in_range)
                    begin
                        $error("degree_in_range: expected %0d, got %0d",
                               want.degree_in_range, degree_in_range);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                verdict_q.push_back(predict_witness(distance_set, vertices,
                                                    degree_lo, degree_hi));
                delta++;
            end
            fail_count  <= fail_count + errs;
            outstanding <= outstanding + delta;
        end
    end

endmodule

>>> verif/circulant_ramsey55_checker_test.sv
`timescale 1ns / 1ps
// ============================================================================
// circulant_ramsey55_checker_test
// Drives distance sets and register settings into the witness checker:
// a directed pass over the corner cases, then random sets under four mixes
// of sender gaps and receiver stalls. A monitor beside the block predicts
// and compares every result; this module only makes stimulus and decides.
// ============================================================================
module circulant_ramsey55_checker_test;
    import cr55_pkg::*;

    localparam int       VERTICES_MAX = 64;
    localparam int       CYCLE_LIMIT  = 50_000_000;
    localparam int       PHASE_ITEMS  = 20;
    localparam int       TAIL_CYCLES  = 100;
    localparam int       FAST_NMAX    = 24;
    localparam cfg_idx_t CFG_SPARE    = 2'd3;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             cfg_write_en = 1'b0;
    logic [IDX_W-1:0] cfg_index    = CFG_VERTEX_COUNT;
    logic [CFG_W-1:0] cfg_data     = '0;
    logic             in_valid     = 1'b0;
    logic [31:0]      distance_set = '0;
    logic             out_stall    = 1'b0;
    logic             in_stall;
    logic             out_valid;
    logic             hit;
    logic [DEG_W-1:0] degree;
    logic             degree_in_range;

    int fail_count;
    int outstanding;
    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;

    circulant_ramsey55_checker #(
        .MAX_VERTICES (VERTICES_MAX)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .distance_set    (distance_set),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hit             (hit),
        .degree          (degree),
        .degree_in_range (degree_in_range)
    );

    cr55_witness_monitor #(
        .MAX_VERTICES (VERTICES_MAX)
    ) u_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .distance_set    (distance_set),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hit             (hit),
        .degree          (degree),
        .degree_in_range (degree_in_range),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sparse, dense and even masks so that degrees spread over the range.
    function automatic logic [31:0] random_set();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom() & $urandom();
            2: return $urandom() | $urandom();
            default: return $urandom() & $urandom() & $urandom();
        endcase
    endfunction

    // Valid stays high from one transfer to the next unless a gap is drawn.
    task automatic send_set(input logic [31:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        distance_set <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Writes all three registers and the unused index back to back.
    task automatic configure(input logic [CFG_W-1:0] vc, input logic [CFG_W-1:0] lo,
                             input logic [CFG_W-1:0] hi);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_VERTEX_COUNT;
        cfg_data     <= vc;
        @(posedge clk);
        cfg_index <= CFG_MIN_DEGREE;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_MAX_DEGREE;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= CFG_W'($urandom());
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic run_phase(input int idle, input int stall);
        int          sent;
        int          burst;
        int unsigned r;
        int unsigned vc;
        int unsigned n;
        int unsigned span;
        int unsigned lo;
        int unsigned hi;
        logic        lo_top;
        logic        hi_top;

        idle_pct  = idle;
        stall_pct <= stall;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            drain();
            r = $urandom_range(99);
            if (r < 8)
                vc = $urandom_range(1);
            else if (r < 18)
                vc = $urandom_range(127, FAST_NMAX + 1);
            else
                vc = $urandom_range(FAST_NMAX, 2);
            n = (vc < 2) ? 2 : ((vc > VERTICES_MAX) ? VERTICES_MAX : vc);
            // Most windows sit around the typical degree so the clique search runs.
            r = $urandom_range(99);
            if (r < 60)
            begin
                span = $urandom_range(4);
                lo   = (n / 2 > span) ? n / 2 - span : 0;
                hi   = (n / 2 + span > 63) ? 63 : n / 2 + span;
            end
            else if (r < 85)
            begin
                lo = 0;
                hi = 63;
            end
            else
            begin
                lo = $urandom_range(63);
                hi = $urandom_range(63);
            end
            lo_top = 1'($urandom_range(1));
            hi_top = 1'($urandom_range(1));
            configure(vc[6:0], {lo_top, lo[5:0]}, {hi_top, hi[5:0]});
            // Large graphs are slow to search, so they get short bursts.
            burst = (n > FAST_NMAX) ? 2 : 6;
            for (int k = 0; k < burst; k++)
                send_set(random_set());
            sent += burst;
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings after reset: 43 vertices, degree 18 to 24.
        send_set(32'h0000_0000);
        send_set(32'hFFFF_FFFF);
        send_set(32'h0000_03FF);
        send_set(32'hFFE0_0000);

        // A count of zero behaves as two vertices.
        drain();
        configure(7'd0, 7'd0, 7'd63);
        send_set(32'h0000_0000);
        send_set(32'h0000_0001);
        send_set(32'hFFFF_FFFE);

        // The pentagon has no triangle at all, so it must be a hit.
        drain();
        configure(7'd5, 7'd2, 7'd2);
        send_set(32'h0000_0001);
        send_set(32'h0000_0002);
        send_set(32'h0000_0003);

        drain();
        configure(7'd8, 7'd0, 7'd63);
        send_set(32'h0000_0008);
        send_set(32'h0000_000F);

        // Count above the maximum saturates to 64 vertices.
        drain();
        configure(7'd127, 7'd63, 7'd63);
        send_set(32'hFFFF_FFFF);
        send_set(32'h8000_0000);

        // Minimum above maximum: nothing can be in range.
        drain();
        configure(7'd65, 7'd40, 7'd10);
        send_set(32'h5555_5555);
        send_set(32'hAAAA_AAAA);

        drain();
        configure(7'd1, 7'd0, 7'd0);
        send_set(32'h0000_0000);

        run_phase(0, 0);
        run_phase(84, 0);
        run_phase(0, 84);
        run_phase(16, 16);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
